// ===== rtl/core/szdd_pkg.sv =====
`default_nettype none

package szdd_pkg;

    localparam int unsigned DEFAULT_WINDOW_SIZE = 4096;
    localparam int unsigned WIN_START_BACK      = 16;
    localparam int unsigned CMD_Q_DEPTH         = 2;

    localparam logic [3:0] HDR_TYPE_IDX  = 4'd8;
    localparam logic [3:0] HDR_LEN0_IDX  = 4'd10;
    localparam logic [3:0] HDR_LEN1_IDX  = 4'd11;
    localparam logic [3:0] HDR_LEN2_IDX  = 4'd12;
    localparam logic [3:0] HDR_LAST_IDX  = 4'd13;
    localparam logic [7:0] HDR_TYPE_A    = 8'h41;
    localparam logic [7:0] FILL_BYTE     = 8'h20;
    localparam logic [4:0] MATCH_BIAS    = 5'd3;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_EARLY = 2'd2;

    typedef enum logic [2:0] {
        K_NOP,
        K_HDR,
        K_BAD,
        K_LIT,
        K_MATCH
    } t_kind;

    // arg: K_HDR declared length, K_LIT byte in [7:0],
    // K_MATCH window position in [11:0] and length nibble in [15:12]
    typedef struct packed {
        t_kind       kind;
        logic        restart;
        logic        eoi;
        logic [31:0] arg;
    } t_cmd;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'h53;
            3'd1: v = 8'h5A;
            3'd2: v = 8'h44;
            3'd3: v = 8'h44;
            3'd4: v = 8'h88;
            3'd5: v = 8'hF0;
            3'd6: v = 8'h27;
            3'd7: v = 8'h33;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/szdd_ifs.sv =====
`default_nettype none

interface szdd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_byte;
    logic       end_of_input;

    modport source (output valid, in_byte, first_byte, end_of_input, input ready);
    modport sink   (input valid, in_byte, first_byte, end_of_input, output ready);
endinterface

interface szdd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, out_byte, status, last, input ready);
    modport sink   (input valid, out_byte, status, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/szdd_front.sv =====
`default_nettype none

module szdd_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    szdd_in_if.sink          i_req,
    input  wire              i_q_full,
    output logic             o_push,
    output szdd_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        F_HDR  = 4'b0001,
        F_TOK  = 4'b0010,
        F_M2   = 4'b0100,
        F_DONE = 4'b1000
    } t_fstate;

    t_fstate     r_state, n_state, e_state;
    logic [3:0]  r_hcnt, n_hcnt, e_hcnt;
    logic        r_ok, n_ok, e_ok;
    logic [31:0] r_len, n_len, e_len;
    logic [15:0] r_flag, n_flag, e_flag;
    logic [7:0]  r_low, n_low, e_low;

    logic        w_acc;
    logic [7:0]  w_b;

    assign i_req.ready = !i_q_full;
    assign w_acc       = i_req.valid && !i_q_full;
    assign w_b         = i_req.in_byte;

    always_comb begin
        if (i_req.first_byte) begin
            e_state = F_HDR;
            e_hcnt  = '0;
            e_ok    = 1'b1;
            e_len   = '0;
            e_flag  = '0;
            e_low   = '0;
        end else begin
            e_state = r_state;
            e_hcnt  = r_hcnt;
            e_ok    = r_ok;
            e_len   = r_len;
            e_flag  = r_flag;
            e_low   = r_low;
        end

        n_state = e_state;
        n_hcnt  = e_hcnt;
        n_ok    = e_ok;
        n_len   = e_len;
        n_flag  = e_flag;
        n_low   = e_low;

        o_cmd.kind    = szdd_pkg::K_NOP;
        o_cmd.restart = i_req.first_byte;
        o_cmd.eoi     = i_req.end_of_input;
        o_cmd.arg     = '0;
        o_push        = 1'b0;

        unique case (e_state)
            F_HDR: begin
                if (e_hcnt < szdd_pkg::HDR_TYPE_IDX) begin
                    if (w_b != szdd_pkg::magic_byte(e_hcnt[2:0])) n_ok = 1'b0;
                end else if (e_hcnt == szdd_pkg::HDR_TYPE_IDX) begin
                    if (w_b != szdd_pkg::HDR_TYPE_A) n_ok = 1'b0;
                end
                unique case (e_hcnt)
                    szdd_pkg::HDR_LEN0_IDX: n_len[7:0]   = e_len[7:0]   | w_b;
                    szdd_pkg::HDR_LEN1_IDX: n_len[15:8]  = e_len[15:8]  | w_b;
                    szdd_pkg::HDR_LEN2_IDX: n_len[23:16] = e_len[23:16] | w_b;
                    szdd_pkg::HDR_LAST_IDX: n_len[31:24] = e_len[31:24] | w_b;
                    default: ;
                endcase
                if (e_hcnt >= szdd_pkg::HDR_LAST_IDX) begin
                    if (!n_ok) begin
                        o_cmd.kind = szdd_pkg::K_BAD;
                        n_state    = F_DONE;
                    end else begin
                        o_cmd.kind = szdd_pkg::K_HDR;
                        o_cmd.arg  = n_len;
                        n_state    = F_TOK;
                    end
                end else begin
                    n_hcnt = e_hcnt + 4'd1;
                end
            end
            F_TOK: begin
                if (!e_flag[8]) begin
                    n_flag = {8'hFF, w_b};
                end else if (e_flag[0]) begin
                    n_flag     = {1'b0, e_flag[15:1]};
                    o_cmd.kind = szdd_pkg::K_LIT;
                    o_cmd.arg  = {24'd0, w_b};
                end else begin
                    n_low   = w_b;
                    n_state = F_M2;
                end
            end
            F_M2: begin
                n_flag     = {1'b0, e_flag[15:1]};
                n_state    = F_TOK;
                o_cmd.kind = szdd_pkg::K_MATCH;
                o_cmd.arg  = {16'd0, w_b[3:0], w_b[7:4], e_low};
            end
            F_DONE: ;
            default: n_state = F_DONE;
        endcase

        if (e_state != F_DONE) begin
            o_push = w_acc && (o_cmd.kind != szdd_pkg::K_NOP || o_cmd.restart || o_cmd.eoi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_HDR;
            r_hcnt  <= '0;
            r_ok    <= 1'b1;
            r_len   <= '0;
            r_flag  <= '0;
            r_low   <= '0;
        end else if (w_acc) begin
            r_state <= n_state;
            r_hcnt  <= n_hcnt;
            r_ok    <= n_ok;
            r_len   <= n_len;
            r_flag  <= n_flag;
            r_low   <= n_low;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/szdd_cmd_q.sv =====
`default_nettype none

module szdd_cmd_q (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  szdd_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_valid,
    output szdd_pkg::t_cmd  o_cmd
);

    localparam int unsigned DEPTH = szdd_pkg::CMD_Q_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    szdd_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CW'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/szdd_back.sv =====
`default_nettype none

module szdd_back #(
    parameter int unsigned WINDOW_SIZE = szdd_pkg::DEFAULT_WINDOW_SIZE
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cmd_valid,
    input  szdd_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    szdd_out_if.source      o_res
);

    localparam int unsigned W = $clog2(WINDOW_SIZE);
    localparam logic [W-1:0] START = W'(WINDOW_SIZE - szdd_pkg::WIN_START_BACK);

    typedef enum logic [3:0] {
        B_CMD  = 4'b0001,
        B_RD   = 4'b0010,
        B_WR   = 4'b0100,
        B_STAT = 4'b1000
    } t_bstate;

    logic [7:0]  r_win [WINDOW_SIZE];
    logic [7:0]  r_rdata;

    t_bstate     r_state, n_state;
    logic [31:0] r_len, n_len;
    logic [31:0] r_cnt, n_cnt;
    logic [W:0]  r_fill, n_fill;
    logic [W-1:0] r_wpos, n_wpos;
    logic [W-1:0] r_pos, n_pos;
    logic [4:0]  r_rem, n_rem;
    logic        r_done, n_done;
    logic        r_eoi, n_eoi;
    logic        r_mem_src, n_mem_src;
    logic        r_hit, n_hit;
    logic [7:0]  r_data, n_data;
    logic [1:0]  r_stat, n_stat;

    logic        r_ov, n_ov;
    logic [7:0]  r_ob, n_ob;
    logic [1:0]  r_os, n_os;
    logic        r_ol, n_ol;

    logic        w_slot, w_we, w_e_done;
    logic [7:0]  w_byte;
    logic [W-1:0] w_diff;

    assign o_res.valid    = r_ov;
    assign o_res.out_byte = r_ob;
    assign o_res.status   = r_os;
    assign o_res.last     = r_ol;

    assign w_slot = !r_ov || o_res.ready;
    assign w_diff = r_pos - START;
    assign w_byte = r_mem_src ? (r_hit ? r_rdata : szdd_pkg::FILL_BYTE) : r_data;

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_fill    = r_fill;
        n_wpos    = r_wpos;
        n_pos     = r_pos;
        n_rem     = r_rem;
        n_done    = r_done;
        n_eoi     = r_eoi;
        n_mem_src = r_mem_src;
        n_hit     = r_hit;
        n_data    = r_data;
        n_stat    = r_stat;
        n_ov      = r_ov && !o_res.ready;
        n_ob      = r_ob;
        n_os      = r_os;
        n_ol      = r_ol;
        o_pop     = 1'b0;
        w_we      = 1'b0;
        w_e_done  = r_done;

        unique case (r_state)
            B_CMD: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.restart) begin
                        n_len    = '0;
                        n_cnt    = '0;
                        n_fill   = '0;
                        n_wpos   = START;
                        n_done   = 1'b0;
                        w_e_done = 1'b0;
                    end
                    n_eoi = i_cmd.eoi;
                    if (!w_e_done) begin
                        unique case (i_cmd.kind)
                            szdd_pkg::K_NOP: begin
                                if (i_cmd.eoi) begin
                                    n_stat  = szdd_pkg::ST_EARLY;
                                    n_state = B_STAT;
                                end
                            end
                            szdd_pkg::K_HDR: begin
                                n_len = i_cmd.arg;
                                if (i_cmd.arg == '0) begin
                                    n_done = 1'b1;
                                end else if (i_cmd.eoi) begin
                                    n_stat  = szdd_pkg::ST_EARLY;
                                    n_state = B_STAT;
                                end
                            end
                            szdd_pkg::K_BAD: begin
                                n_stat  = szdd_pkg::ST_BAD;
                                n_state = B_STAT;
                            end
                            szdd_pkg::K_LIT: begin
                                n_data    = i_cmd.arg[7:0];
                                n_mem_src = 1'b0;
                                n_state   = B_WR;
                            end
                            szdd_pkg::K_MATCH: begin
                                n_pos     = W'(i_cmd.arg[11:0]);
                                n_rem     = {1'b0, i_cmd.arg[15:12]} + szdd_pkg::MATCH_BIAS;
                                n_mem_src = 1'b1;
                                n_state   = B_RD;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            B_RD: begin
                n_hit   = r_fill[W] || ({1'b0, w_diff} < r_fill);
                n_state = B_WR;
            end
            B_WR: begin
                if (w_slot) begin
                    w_we   = 1'b1;
                    n_wpos = r_wpos + W'(1);
                    n_fill = r_fill[W] ? r_fill : r_fill + (W+1)'(1);
                    n_cnt  = r_cnt + 32'd1;
                    n_ov   = 1'b1;
                    n_ob   = w_byte;
                    n_os   = szdd_pkg::ST_DATA;
                    n_ol   = (n_cnt == r_len);
                    if (n_cnt == r_len) begin
                        n_done  = 1'b1;
                        n_state = B_CMD;
                    end else if (r_mem_src && r_rem > 5'd1) begin
                        n_rem   = r_rem - 5'd1;
                        n_pos   = r_pos + W'(1);
                        n_state = B_RD;
                    end else if (r_eoi) begin
                        n_stat  = szdd_pkg::ST_EARLY;
                        n_state = B_STAT;
                    end else begin
                        n_state = B_CMD;
                    end
                end
            end
            B_STAT: begin
                if (w_slot) begin
                    n_ov    = 1'b1;
                    n_ob    = '0;
                    n_os    = r_stat;
                    n_ol    = 1'b1;
                    n_done  = 1'b1;
                    n_state = B_CMD;
                end
            end
            default: n_state = B_CMD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_win[r_wpos] <= w_byte;
        if (r_state == B_RD) r_rdata <= r_win[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CMD;
            r_len   <= '0;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_wpos  <= START;
            r_done  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_fill  <= n_fill;
            r_wpos  <= n_wpos;
            r_done  <= n_done;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_rem     <= n_rem;
        r_eoi     <= n_eoi;
        r_mem_src <= n_mem_src;
        r_hit     <= n_hit;
        r_data    <= n_data;
        r_stat    <= n_stat;
        r_ob      <= n_ob;
        r_os      <= n_os;
        r_ol      <= n_ol;
    end

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_os != szdd_pkg::ST_DATA) |-> (r_ol && r_ob == '0))
        else $error("status result without last or with nonzero byte");

    a_rd_then_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RD) |=> (r_state == B_WR))
        else $error("window read not followed by write-back");

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RD) |-> (r_rem != '0))
        else $error("match copy with no bytes left");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fill[W] && r_fill[W-1:0] != '0))
        else $error("window fill count past window size");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_state == B_CMD && !(i_cmd_valid && i_cmd.restart)) |=> !$rose(r_ov))
        else $error("result produced after end of file");

endmodule

`default_nettype wire

// ===== rtl/core/szdd_lzss_decompressor_top.sv =====
// Channel | Dir | Handshake     | Payload
// i_req   | in  | valid / ready | in_byte[7:0], first_byte, end_of_input
// o_res   | out | valid / ready | out_byte[7:0], status[1:0], last
//
// Input bytes are taken one per cycle while the two-entry command queue has room.
// Literal: one write-back in the decoder. Match (3 to 18 bytes): one
// window read then one write-back per byte through the single 4096x8 window memory.
// Window contents after reset or restart read as spaces via a fill count; no clear pass.
// Reset is synchronous, active low. Results sit in one output register; the decoder
// stalls while it is full and not taken, and input stalls only once the queue is full.
`default_nettype none

module szdd_lzss_decompressor_top #(
    parameter int unsigned WINDOW_SIZE = szdd_pkg::DEFAULT_WINDOW_SIZE
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    szdd_in_if.sink     i_req,
    szdd_out_if.source  o_res
);

    logic            w_push, w_full, w_pop, w_qv;
    szdd_pkg::t_cmd  w_cmd_in, w_cmd_out;

    szdd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    szdd_cmd_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qv),
        .o_cmd   (w_cmd_out)
    );

    szdd_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_qv),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== test/szdd_lzss_decompressor_top_tb.sv =====
`default_nettype none

module szdd_lzss_decompressor_top_tb;

    localparam logic [63:0] SZDD_SIGNATURE = 64'h3327_F088_4444_5A53;
    localparam int          STALL_LIMIT    = 4000;
    localparam int          RANDOM_ITEMS   = 230;

    typedef enum logic [1:0] {
        DEC_HEADER,
        DEC_TOKEN,
        DEC_MATCH2,
        DEC_DONE
    } t_dec_phase;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    szdd_in_if  req_if ();
    szdd_out_if res_if ();

    szdd_lzss_decompressor_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #2 i_clk = ~i_clk;

    // decoder shadow state
    logic [7:0]  hist [4096];
    logic [11:0] hist_wr;
    logic [15:0] tok_flags;
    logic [3:0]  hdr_idx;
    logic        hdr_good;
    logic [31:0] decl_len;
    logic [31:0] emitted;
    logic [7:0]  match_lo;
    t_dec_phase  phase;

    t_res expected_out [$];
    t_res want;
    logic [7:0] stream [$];

    int n_sent;
    int n_results;
    int n_files;
    int n_bad;
    int n_cut;
    int n_match;
    int mism_cnt;
    int idle_cycles;
    int burst_left;
    int tx_gaps;
    int rx_mode;
    int rx_hold;
    int rx_cyc;

    task automatic restart_decoder();
        int i;
        for (i = 0; i < 4096; i++) hist[i] = szdd_pkg::FILL_BYTE;
        hist_wr   = 12'hFF0;
        tok_flags = '0;
        hdr_idx   = '0;
        hdr_good  = 1'b1;
        decl_len  = '0;
        emitted   = '0;
        match_lo  = '0;
        phase     = DEC_HEADER;
    endtask

    task automatic push_status(input logic [1:0] st);
        t_res r;
        r.data   = 8'h00;
        r.status = st;
        r.last   = 1'b1;
        expected_out.push_back(r);
        phase = DEC_DONE;
    endtask

    function automatic bit store_decoded(input logic [7:0] b);
        t_res r;
        hist[hist_wr] = b;
        hist_wr  = hist_wr + 12'd1;
        emitted  = emitted + 32'd1;
        r.data   = b;
        r.status = szdd_pkg::ST_DATA;
        r.last   = (emitted == decl_len);
        expected_out.push_back(r);
        if (r.last) phase = DEC_DONE;
        return r.last;
    endfunction

    task automatic decode_in_byte(input logic [7:0] b, input logic first, input logic eoi);
        logic [11:0] pos;
        int          len;
        int          i;
        if (first) restart_decoder();
        case (phase)
            DEC_HEADER: begin
                if (hdr_idx < 4'd8) begin
                    if (b != SZDD_SIGNATURE[8*hdr_idx +: 8]) hdr_good = 1'b0;
                end else if (hdr_idx == szdd_pkg::HDR_TYPE_IDX) begin
                    if (b != szdd_pkg::HDR_TYPE_A) hdr_good = 1'b0;
                end else if (hdr_idx >= szdd_pkg::HDR_LEN0_IDX) begin
                    decl_len[8*(hdr_idx - szdd_pkg::HDR_LEN0_IDX) +: 8] = b;
                end
                if (hdr_idx == szdd_pkg::HDR_LAST_IDX) begin
                    if (!hdr_good) begin
                        push_status(szdd_pkg::ST_BAD);
                        return;
                    end
                    if (decl_len == 0) begin
                        phase = DEC_DONE;
                        return;
                    end
                    phase = DEC_TOKEN;
                end else begin
                    hdr_idx = hdr_idx + 4'd1;
                end
            end
            DEC_TOKEN: begin
                if (!tok_flags[8]) begin
                    tok_flags = {8'hFF, b};
                end else if (tok_flags[0]) begin
                    tok_flags = tok_flags >> 1;
                    if (store_decoded(b)) return;
                end else begin
                    match_lo = b;
                    phase    = DEC_MATCH2;
                end
            end
            DEC_MATCH2: begin
                pos       = {b[7:4], match_lo};
                len       = int'(b[3:0]) + int'(szdd_pkg::MATCH_BIAS);
                tok_flags = tok_flags >> 1;
                phase     = DEC_TOKEN;
                n_match++;
                for (i = 0; i < len; i++) begin
                    if (store_decoded(hist[pos])) return;
                    pos = pos + 12'd1;
                end
            end
            default: return;
        endcase
        if (eoi) push_status(szdd_pkg::ST_EARLY);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first, input logic eoi);
        int gap;
        @(negedge i_clk);
        req_if.valid        <= 1'b1;
        req_if.in_byte      <= b;
        req_if.first_byte   <= first;
        req_if.end_of_input <= eoi;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        decode_in_byte(b, first, eoi);
        n_sent++;
        if (tx_gaps != 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 6);
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_file(input int eoi_idx);
        int i;
        for (i = 0; i < stream.size(); i++) send_byte(stream[i], i == 0, i == eoi_idx);
        n_files++;
    endtask

    task automatic put_header(input logic [31:0] len, input int bad_bit);
        int         i;
        logic [7:0] v;
        stream.delete();
        for (i = 0; i < 14; i++) begin
            if (i < 8) v = SZDD_SIGNATURE[8*i +: 8];
            else if (i == 8) v = szdd_pkg::HDR_TYPE_A;
            else if (i == 9) v = 8'($urandom);
            else v = len[8*(i-10) +: 8];
            if (bad_bit >= 0 && bad_bit / 8 == i) v[bad_bit % 8] = ~v[bad_bit % 8];
            stream.push_back(v);
        end
    endtask

    // random flag/literal/match tokens covering n_out decoded bytes
    task automatic put_tokens(input int unsigned n_out);
        int unsigned made;
        logic [11:0] wr;
        logic [11:0] off;
        logic [7:0]  flags;
        logic [7:0]  lit;
        logic [3:0]  mlen;
        int          slot;
        made = 0;
        wr   = 12'hFF0;
        slot = 8;
        while (made < n_out) begin
            if (slot == 8) begin
                flags = 8'($urandom);
                stream.push_back(flags);
                slot = 0;
            end
            if (flags[slot]) begin
                lit = 8'($urandom);
                stream.push_back(lit);
                made++;
                wr = wr + 12'd1;
            end else begin
                mlen = 4'($urandom);
                case ($urandom_range(0, 3))
                    0: off = 12'($urandom);
                    1: off = wr - 12'($urandom_range(1, 24));
                    2: off = wr - 12'd1;
                    default: off = 12'hFF0 + 12'($urandom_range(0, 31));
                endcase
                stream.push_back(off[7:0]);
                stream.push_back({off[11:8], mlen});
                made += mlen + 3;
                wr = wr + mlen + 12'd3;
            end
            slot++;
        end
    endtask

    task automatic test_header_faults();
        stream.delete();
        stream.push_back(8'hFF);
        stream.push_back(8'h00);
        stream.push_back(8'h12);
        send_file(-1);
        put_header(5, 8 * szdd_pkg::HDR_TYPE_IDX + 1);
        stream.push_back(8'hFF);
        send_file(-1);
        n_bad++;
    endtask

    task automatic test_zero_length();
        put_header(0, -1);
        stream.push_back(8'h00);
        stream.push_back(8'hFF);
        send_file(stream.size() - 1);
    endtask

    task automatic test_length_reached();
        // match cut short by the declared length, input ends on the same byte
        put_header(10, -1);
        stream.push_back(8'h01);
        stream.push_back(8'h00);
        stream.push_back(8'hFF);
        stream.push_back(8'hFF);
        send_file(stream.size() - 1);
        // overlapping copy across the window wrap, ends exactly on the match
        put_header(19, -1);
        stream.push_back(8'h01);
        stream.push_back(8'h41);
        stream.push_back(8'hF0);
        stream.push_back(8'hFF);
        send_file(stream.size() - 1);
    endtask

    task automatic test_early_end();
        put_header(0, -1);
        while (stream.size() > 5) void'(stream.pop_back());
        send_file(4);
        put_header(50, -1);
        stream.push_back(8'h00);
        stream.push_back(8'h34);
        send_file(stream.size() - 1);
        put_header(50, -1);
        stream.push_back(8'hFF);
        stream.push_back(8'h7E);
        send_file(stream.size() - 1);
        n_cut += 3;
    endtask

    task automatic test_random_files(input int n_items);
        int          start;
        int          kind;
        int          r;
        int          cut;
        int unsigned len;
        start = n_sent;
        while (n_sent - start < n_items) begin
            if ($urandom_range(0, 2) == 0) rx_mode = $urandom_range(0, 3);
            tx_gaps = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 9);
            r       = $urandom_range(0, 19);
            if (r == 0) len = 0;
            else if (r < 14) len = $urandom_range(1, 30);
            else len = $urandom_range(31, 120);
            if (kind == 8) begin
                put_header($urandom, $urandom_range(0, 71));
                n_bad++;
                send_file($urandom_range(0, 1) ? 13 : -1);
            end else begin
                put_header((kind == 7 && $urandom_range(0, 1)) ? $urandom : len, -1);
                put_tokens(len);
                if (kind >= 7) begin
                    cut = $urandom_range(0, stream.size() - 1);
                    while (stream.size() > cut + 1) void'(stream.pop_back());
                    if (kind == 7) n_cut++;
                    send_file(kind == 7 ? cut : -1);
                end else begin
                    repeat ($urandom_range(0, 2)) stream.push_back(8'($urandom));
                    send_file($urandom_range(0, 3) != 0 ? stream.size() - 1 : -1);
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        tx_gaps = 0;
        rx_mode = 0;
        put_header(60, -1);
        put_tokens(60);
        rx_hold = 400;
        send_file(stream.size() - 1);
    endtask

    always @(negedge i_clk) begin
        rx_cyc++;
        if (rx_hold > 0) begin
            res_if.ready <= 1'b0;
            rx_hold--;
        end else begin
            case (rx_mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= ($urandom_range(0, 3) != 0);
                2: res_if.ready <= ((rx_cyc % 7) < 4);
                default: res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_results++;
            if (expected_out.size() == 0) begin
                if (mism_cnt < 10)
                    $display("unexpected result: byte %02h status %0d last %0d",
                             res_if.out_byte, res_if.status, res_if.last);
                mism_cnt++;
            end else begin
                want = expected_out.pop_front();
                if (res_if.out_byte !== want.data || res_if.status !== want.status ||
                    res_if.last !== want.last) begin
                    if (mism_cnt < 10) begin
                        $write("mismatch: expected byte %02h status %0d last %0d,",
                               want.data, want.status, want.last);
                        $display(" got byte %02h status %0d last %0d",
                                 res_if.out_byte, res_if.status, res_if.last);
                    end
                    mism_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == STALL_LIMIT) begin
                $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.in_byte      = 8'h00;
        req_if.first_byte   = 1'b0;
        req_if.end_of_input = 1'b0;
        res_if.ready        = 1'b0;
        n_sent      = 0;
        n_results   = 0;
        n_files     = 0;
        n_bad       = 0;
        n_cut       = 0;
        n_match     = 0;
        mism_cnt    = 0;
        idle_cycles = 0;
        burst_left  = 0;
        rx_cyc      = 0;
        rx_hold     = 0;
        rx_mode     = 1;
        tx_gaps     = 1;
        restart_decoder();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_header_faults();
        test_zero_length();
        test_length_reached();
        test_early_end();
        test_random_files(RANDOM_ITEMS);
        test_output_backpressure();

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Fed %0d requests over %0d files (%0d bad headers, %0d cut short, %0d matches)",
                 n_sent, n_files, n_bad, n_cut, n_match);
        $display("Checked %0d results, %0d mismatches", n_results, mism_cnt);
        if (mism_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
